>>> sv/ecs_pkg.sv
`default_nettype none

package ecs_pkg;

	localparam int DEF_COUNT_WIDTH = 32;
	localparam int DEF_CHANNELS    = 2;

	// The result item always reports the left and the right channel.
	localparam int RES_CHANNELS = 2;
	localparam int DELTA_W      = 16;
	localparam int GAIN_W       = 16;
	localparam int SCALED_W     = 24;
	localparam int Q_SHIFT      = 8;
	localparam int POL_W        = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [POL_W-1:0]  POLARITY_RST   = 2'd1;
	localparam logic [GAIN_W-1:0] RPM_GAIN_RST   = 16'd14043;
	localparam logic [GAIN_W-1:0] SPEED_GAIN_RST = 16'd47794;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLARITY   = 2'd0,
		REG_RPM_GAIN   = 2'd1,
		REG_SPEED_GAIN = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_EDGE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef struct packed {
		logic pulse;
		logic tick;
		logic channel;
		logic b_level;
	} ctrl_t;

endpackage

`default_nettype wire

>>> sv/ecs_counter.sv
`default_nettype none

module ecs_counter #(
	parameter int COUNT_WIDTH = ecs_pkg::DEF_COUNT_WIDTH,
	parameter int CHANNELS    = ecs_pkg::DEF_CHANNELS
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  ecs_pkg::ctrl_t                                          ctrl,
	input  logic [ecs_pkg::POL_W-1:0]                               polarity,
	output logic [ecs_pkg::RES_CHANNELS-1:0][ecs_pkg::DELTA_W-1:0] delta_s1
);
	import ecs_pkg::*;

	logic [COUNT_WIDTH-1:0] pulse_q   [CHANNELS];
	logic [COUNT_WIDTH-1:0] sampled_q [CHANNELS];
	logic                   up;

	// The difference is read as a signed value and clipped to 16 bits.
	function automatic logic [DELTA_W-1:0] sat_delta(input logic [COUNT_WIDTH-1:0] diff);
		logic [COUNT_WIDTH-DELTA_W:0] hi;
		hi = diff[COUNT_WIDTH-1:DELTA_W-1];
		if ((hi == '0) || (hi == '1)) begin
			return diff[DELTA_W-1:0];
		end else if (diff[COUNT_WIDTH-1]) begin
			return {1'b1, {(DELTA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DELTA_W-1){1'b1}}};
		end
	endfunction

	assign up = ctrl.b_level ? polarity[ctrl.channel] : !polarity[ctrl.channel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pulse_q[c]   <= '0;
				sampled_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (ctrl.pulse && (int'(ctrl.channel) == c)) begin
					pulse_q[c] <= up ? pulse_q[c] + 1'b1 : pulse_q[c] - 1'b1;
				end
				if (ctrl.tick) begin
					sampled_q[c] <= pulse_q[c];
				end
			end
		end
	end

	for (genvar r = 0; r < RES_CHANNELS; r++) begin : g_delta
		if (r < CHANNELS) begin : g_live
			always_ff @(posedge clk) begin
				if (ctrl.tick) begin
					delta_s1[r] <= sat_delta(pulse_q[r] - sampled_q[r]);
				end
			end
		end else begin : g_absent
			always_ff @(posedge clk) begin
				if (ctrl.tick) begin
					delta_s1[r] <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/encoder_count_and_speed.sv
`default_nettype none

// Channel   Handshake                 Payload
// item      item_valid / item_stall   command, channel, b_level
// result    result_valid / result_stall  delta_*, rpm_*, speed_* (left, right)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An edge updates its pulse counter at the clock edge that accepts it.
// A tick captures the clipped deltas in the first stage; the gain multipliers
// feed the output register, so a result is registered in both stages.
// One item is accepted per cycle while item_stall is low; item_stall rises only
// while both stages are full and the output is stalled. Reset clears counters and
// valid flags and loads the default polarity and gains.
module encoder_count_and_speed #(
	parameter int COUNT_WIDTH = ecs_pkg::DEF_COUNT_WIDTH,
	parameter int CHANNELS    = ecs_pkg::DEF_CHANNELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  command,
	input  logic                                  channel,
	input  logic                                  b_level,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [ecs_pkg::DELTA_W-1:0]    delta_left,
	output logic signed [ecs_pkg::DELTA_W-1:0]    delta_right,
	output logic signed [ecs_pkg::SCALED_W-1:0]   rpm_left,
	output logic signed [ecs_pkg::SCALED_W-1:0]   rpm_right,
	output logic signed [ecs_pkg::SCALED_W-1:0]   speed_left,
	output logic signed [ecs_pkg::SCALED_W-1:0]   speed_right,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ecs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ecs_pkg::GAIN_W-1:0]            cfg_data
);
	import ecs_pkg::*;

	localparam int PROD_W = DELTA_W + GAIN_W + 1;

	logic [POL_W-1:0]  polarity_q;
	logic [GAIN_W-1:0] rpm_gain_q;
	logic [GAIN_W-1:0] speed_gain_q;

	logic  s1_valid_q;
	logic  out_valid_q;
	logic  out_adv;
	logic  s1_adv;
	logic  accept;
	ctrl_t ctrl;

	logic [RES_CHANNELS-1:0][DELTA_W-1:0] delta_s1;
	logic signed [PROD_W-1:0] rpm_prod   [RES_CHANNELS];
	logic signed [PROD_W-1:0] speed_prod [RES_CHANNELS];

	logic [DELTA_W-1:0]  delta_q [RES_CHANNELS];
	logic [SCALED_W-1:0] rpm_q   [RES_CHANNELS];
	logic [SCALED_W-1:0] speed_q [RES_CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q   <= POLARITY_RST;
			rpm_gain_q   <= RPM_GAIN_RST;
			speed_gain_q <= SPEED_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLARITY:   polarity_q   <= cfg_data[POL_W-1:0];
				REG_RPM_GAIN:   rpm_gain_q   <= cfg_data;
				REG_SPEED_GAIN: speed_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_adv    = !out_valid_q || !result_stall;
	assign s1_adv     = s1_valid_q && out_adv;
	assign item_stall = s1_valid_q && !out_adv;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		ctrl.pulse   = accept && (command == CMD_EDGE);
		ctrl.tick    = accept && (command == CMD_TICK);
		ctrl.channel = channel;
		ctrl.b_level = b_level;
	end

	ecs_counter #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.CHANNELS    (CHANNELS)
	) u_counter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.polarity (polarity_q),
		.delta_s1 (delta_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.tick) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Taking bits 31:8 of the product is the floor of the product over 256.
	for (genvar r = 0; r < RES_CHANNELS; r++) begin : g_scale
		assign rpm_prod[r]   = $signed(delta_s1[r]) * $signed({1'b0, rpm_gain_q});
		assign speed_prod[r] = $signed(delta_s1[r]) * $signed({1'b0, speed_gain_q});

		always_ff @(posedge clk) begin
			if (s1_adv) begin
				delta_q[r] <= delta_s1[r];
				rpm_q[r]   <= rpm_prod[r][SCALED_W+Q_SHIFT-1:Q_SHIFT];
				speed_q[r] <= speed_prod[r][SCALED_W+Q_SHIFT-1:Q_SHIFT];
			end
		end
	end

	assign result_valid = out_valid_q;
	assign delta_left   = delta_q[0];
	assign delta_right  = delta_q[1];
	assign rpm_left     = rpm_q[0];
	assign rpm_right    = rpm_q[1];
	assign speed_left   = speed_q[0];
	assign speed_right  = speed_q[1];

endmodule

`default_nettype wire

>>> sv/ecs_checker.sv
`default_nettype none

module ecs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                command,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic signed [ecs_pkg::DELTA_W-1:0]  delta_left,
	input logic signed [ecs_pkg::DELTA_W-1:0]  delta_right,
	input logic signed [ecs_pkg::SCALED_W-1:0] rpm_left,
	input logic signed [ecs_pkg::SCALED_W-1:0] rpm_right,
	input logic signed [ecs_pkg::SCALED_W-1:0] speed_left,
	input logic signed [ecs_pkg::SCALED_W-1:0] speed_right
);

	// A stalled result keeps result_valid, delta_left, rpm_right and speed_left stable.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(delta_left)
			&& $stable(rpm_right) && $stable(speed_left))
		else $error("stalled result changed");

	// A fresh result must stem from an accepted tick; edges make none.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall && command, 2))
		else $error("result without a tick");

	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (delta_left == 0) && (delta_right == 0) |->
			(rpm_left == 0) && (speed_left == 0) && (rpm_right == 0) && (speed_right == 0))
		else $error("zero delta gave nonzero speed");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (delta_left > 0) && (delta_right > 0) |->
			(rpm_left >= 0) && (speed_left >= 0) && (rpm_right >= 0) && (speed_right >= 0))
		else $error("speed sign disagrees with delta");

endmodule

bind encoder_count_and_speed ecs_checker u_ecs_checker (.*);

`default_nettype wire
